[design/triangle_min_path_sum_core_macros.svh]
// assertion macros for the triangle minimum path sum core
`ifndef TRIANGLE_MIN_PATH_SUM_CORE_MACROS_SVH
`define TRIANGLE_MIN_PATH_SUM_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define TMPS_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);
`define TMPS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TMPS_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg)
`define TMPS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)
`endif

`endif

[design/tmps_pkg.sv]
// shared types and constants for the triangle minimum path sum core
package tmps_pkg;

    localparam int MAX_ROWS_DEF = 256;
    localparam int VALUE_W      = 16;
    localparam int SUM_W        = 24;
    localparam int COUNT_W      = 9;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [COUNT_W-1:0]        count_t;

    typedef struct packed {
        logic first_row;
        logic use_left;
        logic use_mid;
        logic use_right;
    } nbr_sel_t;

    localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

endpackage

[design/tmps_ram.sv]
// generic single-write, single-read ram with registered read data
module tmps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/tmps_best.sv]
// best sum of one cell: least existing neighbor plus the entry, saturated
module tmps_best (
    input  tmps_pkg::value_t   value,
    input  tmps_pkg::nbr_sel_t sel,
    input  tmps_pkg::sum_t     left,
    input  tmps_pkg::sum_t     mid,
    input  tmps_pkg::sum_t     right,
    output tmps_pkg::sum_t     best
);

    localparam int EXT_W = tmps_pkg::SUM_W + 1;

    tmps_pkg::sum_t          m;
    logic                    have;
    logic signed [EXT_W-1:0] sum;

    always_comb
    begin
        m    = left;
        have = 1'b0;
        if (sel.use_left)
        begin
            m    = left;
            have = 1'b1;
        end
        if (sel.use_mid && (!have || mid < m))
        begin
            m    = mid;
            have = 1'b1;
        end
        if (sel.use_right && (!have || right < m))
        begin
            m    = right;
        end
    end

    assign sum = {m[tmps_pkg::SUM_W-1], m}
               + {{(EXT_W-tmps_pkg::VALUE_W){value[tmps_pkg::VALUE_W-1]}}, value};

    always_comb
    begin
        if (sel.first_row)
        begin
            best = {{(tmps_pkg::SUM_W-tmps_pkg::VALUE_W){value[tmps_pkg::VALUE_W-1]}}, value};
        end
        else if (sum[EXT_W-1] != sum[EXT_W-2])
        begin
            best = sum[EXT_W-1] ? tmps_pkg::SUM_MIN : tmps_pkg::SUM_MAX;
        end
        else
        begin
            best = sum[tmps_pkg::SUM_W-1:0];
        end
    end

endmodule

[design/triangle_min_path_sum_core.sv]
// top level of the streaming triangle minimum path sum core
//
// entries of a number triangle arrive on value, row-major, row r holding r+1
// entries; an entry transfers at a clock edge where start is high and busy is
// low. busy is always low: one entry is taken every cycle with no gaps needed.
// after the last entry of the final row, done pulses for one cycle with the
// least path sum of that row on min_sum.
// the receiver cannot hold results off; done and min_sum are registered.
// the previous row lives in a two-bank ram read two columns past the next cell, so a three
// entry window slides along it; one ram read and write per cycle set the rate.
// row_count is written through cfg_wr_en / cfg_wr_data while idle: zero means
// one row, values above MAX_ROWS saturate. a write mid-triangle acts at once.
// reset (rst_n low, asynchronous) returns to row 0, column 0, bank 0, row
// count 1; no clearing pass is needed since only rows already written are read.
module triangle_min_path_sum_core #(
    parameter int MAX_ROWS = tmps_pkg::MAX_ROWS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  tmps_pkg::value_t         value,
    output logic                     done,
    output tmps_pkg::sum_t           min_sum,
    input  logic                     cfg_wr_en,
    input  logic [tmps_pkg::COUNT_W-1:0] cfg_wr_data
);

`include "triangle_min_path_sum_core_macros.svh"

    localparam int IDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ADDR_W = IDX_W + 1;
    localparam int CMP_W  = IDX_W + tmps_pkg::COUNT_W + 1;

    logic                   in_valid_reg;
    tmps_pkg::value_t       value_reg;
    logic [IDX_W-1:0]       row_reg, row_next;
    logic [IDX_W-1:0]       col_reg, col_next;
    logic                   bank_reg, bank_next;
    tmps_pkg::sum_t         run_min_reg, run_min_next;
    tmps_pkg::count_t       row_count_reg;
    tmps_pkg::sum_t         win_l_reg, win_m_reg, win_r_reg;
    tmps_pkg::sum_t         head0_reg, head1_reg;
    logic                   fwd_valid_reg;
    tmps_pkg::sum_t         fwd_data_reg;
    logic                   done_reg;
    tmps_pkg::sum_t         min_sum_reg;

    tmps_pkg::nbr_sel_t     sel;
    tmps_pkg::sum_t         best;
    tmps_pkg::sum_t         ram_rdata;
    tmps_pkg::sum_t         rd_eff;
    logic [ADDR_W-1:0]      waddr, raddr;
    logic [IDX_W-1:0]       col_ahead;
    logic [CMP_W-1:0]       rows_eff;
    logic                   row_end;
    logic                   last_row;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            value_reg <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= tmps_pkg::COUNT_W'(1);
        end
        else if (cfg_wr_en)
        begin
            row_count_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_eff = CMP_W'(1);
        end
        else if (CMP_W'(row_count_reg) > CMP_W'(MAX_ROWS))
        begin
            rows_eff = CMP_W'(MAX_ROWS);
        end
        else
        begin
            rows_eff = CMP_W'(row_count_reg);
        end
    end

    assign sel.first_row = (row_reg == '0);
    assign sel.use_left  = (col_reg != '0);
    assign sel.use_mid   = (col_reg < row_reg);
    assign sel.use_right = ((ADDR_W'(col_reg) + ADDR_W'(1)) < ADDR_W'(row_reg));

    assign rd_eff = fwd_valid_reg ? fwd_data_reg : ram_rdata;

    tmps_best u_best (
        .value (value_reg),
        .sel   (sel),
        .left  (win_l_reg),
        .mid   (win_m_reg),
        .right (win_r_reg),
        .best  (best)
    );

    assign row_end  = (col_reg >= row_reg);
    assign last_row = ((CMP_W'(row_reg) + CMP_W'(1)) >= rows_eff);

    always_comb
    begin
        row_next     = row_reg;
        col_next     = col_reg;
        bank_next    = bank_reg;
        run_min_next = run_min_reg;
        if (in_valid_reg)
        begin
            run_min_next = ((col_reg == '0) || (best < run_min_reg)) ? best : run_min_reg;
            if (row_end)
            begin
                col_next  = '0;
                bank_next = ~bank_reg;
                row_next  = last_row ? '0 : row_reg + IDX_W'(1);
            end
            else
            begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    // prefetch the previous-row entry two columns past the next cell
    assign col_ahead = col_next + IDX_W'(2);
    assign raddr     = {~bank_next, col_ahead};
    assign waddr     = {bank_reg, col_reg};

    tmps_ram #(
        .WIDTH (tmps_pkg::SUM_W),
        .DEPTH (2 ** ADDR_W)
    ) u_row_store (
        .clk   (clk),
        .we    (in_valid_reg),
        .waddr (waddr),
        .wdata (best),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            bank_reg      <= 1'b0;
            run_min_reg   <= '0;
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            bank_reg      <= bank_next;
            run_min_reg   <= run_min_next;
            fwd_valid_reg <= in_valid_reg && (waddr == raddr);
            done_reg      <= in_valid_reg && row_end && last_row;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= best;
        if (in_valid_reg)
        begin
            if (col_reg == '0)
            begin
                head0_reg <= best;
            end
            if (col_reg == IDX_W'(1))
            begin
                head1_reg <= best;
            end
            if (row_end)
            begin
                win_l_reg <= head0_reg;
                win_m_reg <= (col_reg == '0) ? best : head0_reg;
                win_r_reg <= (col_reg == IDX_W'(1)) ? best : head1_reg;
            end
            else
            begin
                win_l_reg <= win_m_reg;
                win_m_reg <= win_r_reg;
                win_r_reg <= rd_eff;
            end
            if (row_end && last_row)
            begin
                min_sum_reg <= run_min_next;
            end
        end
    end

    assign done    = done_reg;
    assign min_sum = min_sum_reg;

    `TMPS_ASSERT_NEXT(a_done_needs_item, clk, rst_n, !in_valid_reg, !done_reg, "result without a transfer")
    `TMPS_ASSERT_SAME(a_col_within_row, clk, rst_n, 1'b1, col_reg <= row_reg, "column past end of row")
    `TMPS_ASSERT_SAME(a_done_restarts, clk, rst_n, done_reg, (row_reg == '0) && (col_reg == '0), "no restart after result")
    `TMPS_ASSERT_NEXT(a_bank_flips, clk, rst_n, in_valid_reg && row_end, bank_reg != $past(bank_reg), "bank not switched at row end")

endmodule
